// File: hw/rtl/dtu_pkg.sv
// ----------------------------------------------------------------------------
// dtu_pkg
// Shared types, constants and lookup tables of the dictionary text decoder.
// ----------------------------------------------------------------------------
package dtu_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [15:0] code_point;
    logic [1:0]  error_code;
    logic        last_out;
  } out_t;

  typedef struct packed {
    logic produce;
    out_t data;
  } res_t;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_BAD   = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  localparam logic [7:0] LEAD_MIN   = 8'ha0;
  localparam logic [7:0] LEAD_TWO   = 8'hf6;
  localparam logic [7:0] LEAD_THREE = 8'hfc;
  localparam logic [7:0] ROW_MIN    = 8'ha1;

  localparam logic [7:0]  TRAIL_BIAS    = 8'h21;
  localparam logic [7:0]  TRAIL_SPAN    = 8'h5e;
  localparam logic [15:0] ROW_OFFSET    = 16'h5edf;
  localparam logic [15:0] ROW_STRIDE    = 16'h00be;
  localparam logic [15:0] LINEAR_BASE   = 16'h0100;

  localparam logic [15:0] IDX_NBSP      = 16'h25ff;
  localparam logic [15:0] IDX_FIG_DASH  = 16'h25fe;
  localparam logic [15:0] IDX_EM_DASH   = 16'h25fd;
  localparam logic [15:0] IDX_TIE       = 16'h036e;
  localparam logic [15:0] IDX_NULL      = 16'h036f;
  localparam logic [15:0] ROM_BASE      = 16'h0203;
  localparam logic [15:0] ROM_LAST      = 16'h0041;

  localparam logic [15:0] CP_NBSP       = 16'h00a0;
  localparam logic [15:0] CP_FIG_DASH   = 16'h2012;
  localparam logic [15:0] CP_EM_DASH    = 16'h2014;
  localparam logic [15:0] CP_TIE        = 16'h035c;

  localparam logic [15:0] CP_BACKSLASH  = 16'h005c;
  localparam logic [15:0] CP_UPPER_S    = 16'h0053;
  localparam logic [15:0] CP_LBRACE     = 16'h007b;
  localparam logic [15:0] CP_RBRACE     = 16'h007d;

  function automatic logic [15:0] glyph_rom(input logic [6:0] addr);
    logic [15:0] v;
    case (addr)
      7'd0:  v = 16'h2992;  7'd1:  v = 16'h2694;  7'd2:  v = 16'h0000;
      7'd3:  v = 16'h0294;  7'd4:  v = 16'h00ae;  7'd5:  v = 16'h2655;
      7'd6:  v = 16'h26ae;  7'd7:  v = 16'h26ad;  7'd8:  v = 16'h007e;
      7'd9:  v = 16'h0000;  7'd10: v = 16'h020d;  7'd11: v = 16'h020e;
      7'd12: v = 16'h020f;  7'd13: v = 16'h0210;  7'd14: v = 16'h00e6;
      7'd15: v = 16'h00e7;  7'd16: v = 16'h00f0;  7'd17: v = 16'h00f8;
      7'd18: v = 16'h0127;  7'd19: v = 16'h014b;  7'd20: v = 16'h0153;
      7'd21: v = 16'h03b2;  7'd22: v = 16'h03b8;  7'd23: v = 16'h0111;
      7'd24: v = 16'h0180;  7'd25: v = 16'h021c;  7'd26: v = 16'h0195;
      7'd27: v = 16'h021e;  7'd28: v = 16'h021f;  7'd29: v = 16'h0220;
      7'd30: v = 16'h0061;  7'd31: v = 16'h0062;  7'd32: v = 16'h0063;
      7'd33: v = 16'h0064;  7'd34: v = 16'h0065;  7'd35: v = 16'h0066;
      7'd36: v = 16'h0067;  7'd37: v = 16'h0068;  7'd38: v = 16'h0069;
      7'd39: v = 16'h006a;  7'd40: v = 16'h006b;  7'd41: v = 16'h006c;
      7'd42: v = 16'h006d;  7'd43: v = 16'h006e;  7'd44: v = 16'h006f;
      7'd45: v = 16'h0070;  7'd46: v = 16'h0071;  7'd47: v = 16'h0072;
      7'd48: v = 16'h0073;  7'd49: v = 16'h0074;  7'd50: v = 16'h0075;
      7'd51: v = 16'h0076;  7'd52: v = 16'h0077;  7'd53: v = 16'h0078;
      7'd54: v = 16'h0079;  7'd55: v = 16'h007a;  7'd56: v = 16'h023b;
      7'd57: v = 16'h023c;  7'd58: v = 16'h023d;  7'd59: v = 16'h023e;
      7'd60: v = 16'h023f;  7'd61: v = 16'h0240;  7'd62: v = 16'h0241;
      7'd63: v = 16'h0242;  7'd64: v = 16'h0152;  7'd65: v = 16'h0153;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] cp1252_high(input logic [4:0] addr);
    logic [15:0] v;
    case (addr)
      5'd0:  v = 16'h20ac;  5'd1:  v = 16'h0081;  5'd2:  v = 16'h201a;
      5'd3:  v = 16'h0192;  5'd4:  v = 16'h201e;  5'd5:  v = 16'h2026;
      5'd6:  v = 16'h2020;  5'd7:  v = 16'h2021;  5'd8:  v = 16'h02c6;
      5'd9:  v = 16'h2030;  5'd10: v = 16'h0160;  5'd11: v = 16'h2039;
      5'd12: v = 16'h0152;  5'd13: v = 16'h008d;  5'd14: v = 16'h017d;
      5'd15: v = 16'h008f;  5'd16: v = 16'h0090;  5'd17: v = 16'h2018;
      5'd18: v = 16'h2019;  5'd19: v = 16'h201c;  5'd20: v = 16'h201d;
      5'd21: v = 16'h2022;  5'd22: v = 16'h2013;  5'd23: v = 16'h2014;
      5'd24: v = 16'h02dc;  5'd25: v = 16'h2122;  5'd26: v = 16'h0161;
      5'd27: v = 16'h203a;  5'd28: v = 16'h0153;  5'd29: v = 16'h009d;
      5'd30: v = 16'h017e;  5'd31: v = 16'h0178;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/dtu_decode.sv
// ----------------------------------------------------------------------------
// dtu_decode
// Maps one complete character value (a single byte, or lead and trail byte) to a code point.
// ----------------------------------------------------------------------------
module dtu_decode (
  input  logic [15:0] char_val,
  output logic [15:0] code_point
);
  import dtu_pkg::*;

  logic [7:0]  lead;
  logic [7:0]  trail;
  logic [7:0]  col_a;
  logic [7:0]  col;
  logic [15:0] row_sum;
  logic [15:0] row_prod;
  logic [15:0] idx_lin;
  logic [15:0] idx;
  logic [15:0] rom_off;
  logic [15:0] mid;

  assign lead  = char_val[15:8];
  assign trail = char_val[7:0];

  // row and column of a two byte glyph
  assign col_a    = trail - TRAIL_BIAS;
  assign col      = (col_a > TRAIL_SPAN) ? (col_a - TRAIL_BIAS) : col_a;
  assign row_sum  = char_val + ROW_OFFSET;
  assign row_prod = {8'h00, row_sum[15:8]} * ROW_STRIDE;
  assign idx_lin  = row_prod + {8'h00, col} + LINEAR_BASE;

  assign idx     = (lead < ROW_MIN) ? {8'h00, trail} : idx_lin;
  assign rom_off = idx - ROM_BASE;

  always_comb begin
    if (idx == IDX_NBSP) begin
      mid = CP_NBSP;
    end else if (idx == IDX_FIG_DASH) begin
      mid = CP_FIG_DASH;
    end else if (idx == IDX_EM_DASH) begin
      mid = CP_EM_DASH;
    end else if (rom_off <= ROM_LAST) begin
      mid = glyph_rom(rom_off[6:0]);
    end else if (idx == IDX_TIE) begin
      mid = CP_TIE;
    end else if (idx == IDX_NULL) begin
      mid = 16'h0000;
    end else begin
      mid = idx;
    end
  end

  // windows-1252 upper control range
  assign code_point = (mid[15:5] == 11'b000_0000_0100) ? cp1252_high(mid[4:0]) : mid;

endmodule

// File: hw/rtl/dtu_ctrl.sv
// ----------------------------------------------------------------------------
// dtu_ctrl
// Per-string state: character gathering, raw passthrough, error dropping.
// ----------------------------------------------------------------------------
module dtu_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  dtu_pkg::in_t item,
  output dtu_pkg::res_t res
);
  import dtu_pkg::*;

  logic [1:0]  need_r, need_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic        raw_r, raw_nxt;
  logic        bs_r, bs_nxt;
  logic        bss_r, bss_nxt;
  logic        failed_r, failed_nxt;

  logic [7:0]  b;
  logic        last;
  logic [1:0]  need_dec;
  logic [15:0] dec_val;
  logic [15:0] dec_cp;
  logic [15:0] cp;
  logic        emit_cp;
  logic        clear;

  assign b        = item.byte_in;
  assign last     = item.end_of_string;
  assign need_dec = need_r - 2'd1;
  assign dec_val  = (need_r == 2'd0) ? {8'h00, b} : {lead_r, b};

  dtu_decode u_decode (
    .char_val   (dec_val),
    .code_point (dec_cp)
  );

  always_comb begin
    need_nxt   = need_r;
    lead_nxt   = lead_r;
    raw_nxt    = raw_r;
    bs_nxt     = bs_r;
    bss_nxt    = bss_r;
    failed_nxt = failed_r;
    res        = '0;
    res.data.last_out = last;
    emit_cp    = 1'b0;
    cp         = dec_cp;
    clear      = last;

    if (failed_r) begin
      res.produce = 1'b0;
    end else if (raw_r) begin
      cp      = {8'h00, b};
      emit_cp = 1'b1;
    end else if (need_r == 2'd0) begin
      if (b < LEAD_MIN) begin
        emit_cp = 1'b1;
      end else begin
        lead_nxt = b;
        need_nxt = (b >= LEAD_THREE) ? 2'd3 : ((b >= LEAD_TWO) ? 2'd2 : 2'd1);
        if (last) begin
          res.produce         = 1'b1;
          res.data.error_code = ERR_TRUNC;
        end
      end
    end else if (need_dec != 2'd0) begin
      need_nxt = need_dec;
      if (last) begin
        res.produce         = 1'b1;
        res.data.error_code = ERR_TRUNC;
      end
    end else begin
      need_nxt = 2'd0;
      if (lead_r >= LEAD_TWO) begin
        res.produce         = 1'b1;
        res.data.error_code = ERR_BAD;
        failed_nxt          = !last;
      end else begin
        emit_cp = 1'b1;
      end
    end

    if (emit_cp) begin
      if (cp == CP_RBRACE) begin
        raw_nxt = 1'b0;
      end
      if (cp == CP_LBRACE && bss_r) begin
        raw_nxt = 1'b1;
      end
      bss_nxt             = bs_r && (cp == CP_UPPER_S);
      bs_nxt              = (cp == CP_BACKSLASH);
      res.produce         = 1'b1;
      res.data.code_point = cp;
      res.data.error_code = ERR_OK;
    end

    // end of string returns all state to idle
    if (clear) begin
      need_nxt   = 2'd0;
      raw_nxt    = 1'b0;
      bs_nxt     = 1'b0;
      bss_nxt    = 1'b0;
      failed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r   <= 2'd0;
      raw_r    <= 1'b0;
      bs_r     <= 1'b0;
      bss_r    <= 1'b0;
      failed_r <= 1'b0;
    end else if (step) begin
      need_r   <= need_nxt;
      raw_r    <= raw_nxt;
      bs_r     <= bs_nxt;
      bss_r    <= bss_nxt;
      failed_r <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      lead_r <= lead_nxt;
    end
  end

endmodule

// File: hw/rtl/dictionary_text_to_unicode.sv
// ----------------------------------------------------------------------------
// dictionary_text_to_unicode
// Decodes encoded dictionary string bytes into one code point per character.
// ----------------------------------------------------------------------------
//   channel | ports                          | carries
//   in      | in_valid in_stall in_data      | byte_in, end_of_string
//   out     | out_valid out_stall out_data   | code_point, error_code, last_out
//
// one byte per cycle sustained while no result waits on out_stall
// the input register feeds the decode and state update, the result register
// holds the code point until the out transaction
// synchronous reset returns all string state to idle; no clearing pass
// a byte that gives no result never waits on out_stall
// ----------------------------------------------------------------------------
module dictionary_text_to_unicode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dtu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dtu_pkg::out_t out_data
);
  import dtu_pkg::*;

  logic s1_valid_r, s1_valid_nxt;
  in_t  s1_data_r;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  res_t res;
  logic out_free;
  logic s1_adv;
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!res.produce || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  dtu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .item  (s1_data_r),
    .res   (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv && res.produce) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && res.produce) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/dtu_checker.sv
// ----------------------------------------------------------------------------
// dtu_checker
// Port-level checks of the dictionary text decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dtu_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input dtu_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input dtu_pkg::out_t out_data
);
  import dtu_pkg::*;

  // input only backs up when a result is stuck at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code != ERR_OK) |-> (out_data.code_point == 16'h0000))
    else $error("error result with nonzero code point");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code == ERR_TRUNC) |-> out_data.last_out)
    else $error("truncation reported before end of string");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind dictionary_text_to_unicode dtu_checker u_dtu_checker (.*);
